[hw/rtl/rau_pkg.sv]
// shared types and constants for the rational arithmetic unit
`default_nettype none

package rau_pkg;

	// default datapath word width
	localparam int DEF_WORD_BITS = 32;

	// fixed port field widths
	localparam int OP_BITS  = 4;
	localparam int NUM_BITS = 32;
	localparam int DEN_BITS = 31;

	// request opcodes
	typedef enum logic [OP_BITS-1:0] {
		OP_NORM  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_EQ    = 4'd5,
		OP_NE    = 4'd6,
		OP_LT    = 4'd7,
		OP_LE    = 4'd8,
		OP_GT    = 4'd9,
		OP_GE    = 4'd10,
		OP_FLOOR = 4'd11,
		OP_FRAC  = 4'd12
	} rau_op_t;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		UOP_NONE     = 5'd0,
		UOP_LOAD     = 5'd1,
		UOP_RES_ZERO = 5'd2,
		UOP_N_CHK    = 5'd3,
		UOP_G_STEP   = 5'd4,
		UOP_G_SHIFT  = 5'd5,
		UOP_G_END    = 5'd6,
		UOP_DIV_QN   = 5'd7,
		UOP_SAVE_QN  = 5'd8,
		UOP_DIV_QD   = 5'd9,
		UOP_N_END    = 5'd10,
		UOP_FAIL     = 5'd11,
		UOP_SET_A    = 5'd12,
		UOP_SET_B    = 5'd13,
		UOP_RES_A    = 5'd14,
		UOP_MUL_1    = 5'd15,
		UOP_MUL_2    = 5'd16,
		UOP_LD_PROD  = 5'd17,
		UOP_CMP      = 5'd18,
		UOP_DIV_FL   = 5'd19,
		UOP_FLOOR    = 5'd20,
		UOP_AS_EQ    = 5'd21,
		UOP_AS_GCD   = 5'd22,
		UOP_DIV_L    = 5'd23,
		UOP_MUL_L    = 5'd24,
		UOP_SAVE_L   = 5'd25,
		UOP_DIV_TA   = 5'd26,
		UOP_MUL_TA   = 5'd27,
		UOP_SAVE_TA  = 5'd28,
		UOP_MUL_TB   = 5'd29,
		UOP_SUM      = 5'd30,
		UOP_FIN      = 5'd31
	} rau_uop_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic               nd_zero;
		logic               gb_zero;
		logic               nok;
		logic               div_done;
		logic               ad_eq_bd;
	} rau_sts_t;

endpackage

`default_nettype wire

[hw/rtl/rau_if.sv]
// request and result channel interfaces
`default_nettype none

interface rau_in_if import rau_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_BITS-1:0]         opcode;
	logic signed [NUM_BITS-1:0] a_num;
	logic signed [NUM_BITS-1:0] a_den;
	logic signed [NUM_BITS-1:0] b_num;
	logic [DEN_BITS-1:0]        b_den;

	modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [NUM_BITS-1:0] res_num;
	logic [DEN_BITS-1:0]        res_den;
	logic                       truth;
	logic                       status;

	modport source (output valid, res_num, res_den, truth, status, input ready);
	modport sink (input valid, res_num, res_den, truth, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/rau_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rau_div import rau_pkg::*; #(
	parameter int W = DEF_WORD_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quo,
	output logic [W-1:0]      rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    shifted, diff;

	// trial subtraction of the divisor
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[hw/rtl/rau_dp.sv]
// datapath: operand registers, shared multiplier and divider
`default_nettype none

module rau_dp import rau_pkg::*; #(
	parameter int W = DEF_WORD_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rau_uop_t                   uop,
	input  wire logic [OP_BITS-1:0]         opcode,
	input  wire logic signed [NUM_BITS-1:0] a_num,
	input  wire logic signed [NUM_BITS-1:0] a_den,
	input  wire logic signed [NUM_BITS-1:0] b_num,
	input  wire logic [DEN_BITS-1:0]        b_den,
	output rau_sts_t                        sts,
	output logic signed [NUM_BITS-1:0]      res_num,
	output logic [DEN_BITS-1:0]             res_den,
	output logic                            truth,
	output logic                            status
);

	localparam int PW = 2 * W + 2;
	localparam logic [W-2:0]        RD_ONE = (W-1)'(1);
	localparam logic signed [W-1:0] W_ONE  = W'(1);

	logic [OP_BITS-1:0]    op_q;
	logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q, bn0_q, bd0_q, nn_q, nd_q;
	logic signed [W-1:0]   on_q, od_q, mx_q, mi_q, l_q, ta_q, t1_q, rn_q;
	logic [W-1:0]          ga_q, gb_q, g_q, qn_q;
	logic [W-2:0]          rd_q;
	logic                  nok_q, truth_q, status_q;
	logic signed [PW-1:0]  prod_q, x_q;
	logic [NUM_BITS-1:0]   bd_ext;

	logic                  div_start, div_done;
	logic [W-1:0]          div_dvd, div_dvs, div_quo, div_rem;
	logic signed [W:0]     ma, mb;
	logic signed [W-1:0]   pw, fl, neg_pw, sum;
	logic                  sub, neg, eq, lt, cmp_r;

	// magnitude of a signed word as an unsigned word
	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	assign bd_ext = {1'b0, b_den};
	assign pw     = prod_q[W-1:0];
	assign neg_pw = -pw;
	assign sub    = (op_q == OP_SUB) || (op_q == OP_FRAC);
	assign neg    = nn_q[W-1] != nd_q[W-1];

	// floor of a from quotient and remainder of |a| / d
	always_comb begin
		if (!an_q[W-1])
			fl = div_quo;
		else if (div_rem != '0)
			fl = ~div_quo;
		else
			fl = ~div_quo + 1'b1;
	end

	// numerator combine for add and subtract
	assign sum = ((sub ^ l_q[W-1]) != 1'b0) ? (ta_q - pw) : (ta_q + pw);

	// exact comparison of the cross products
	assign eq = x_q == prod_q;
	assign lt = x_q < prod_q;
	always_comb begin
		case (op_q)
			OP_EQ:   cmp_r = eq;
			OP_NE:   cmp_r = ~eq;
			OP_LT:   cmp_r = lt;
			OP_LE:   cmp_r = lt | eq;
			OP_GT:   cmp_r = ~(lt | eq);
			OP_GE:   cmp_r = ~lt;
			default: cmp_r = 1'b0;
		endcase
	end

	// divider operand selection
	always_comb begin
		div_start = 1'b1;
		div_dvd   = '0;
		div_dvs   = '0;
		case (uop)
			UOP_G_STEP: begin
				div_dvd = ga_q;
				div_dvs = gb_q;
			end
			UOP_DIV_QN: begin
				div_dvd = mag(nn_q);
				div_dvs = g_q;
			end
			UOP_DIV_QD: begin
				div_dvd = mag(nd_q);
				div_dvs = g_q;
			end
			UOP_DIV_FL: begin
				div_dvd = mag(an_q);
				div_dvs = ad_q;
			end
			UOP_DIV_L: begin
				div_dvd = mx_q;
				div_dvs = g_q;
			end
			UOP_DIV_TA: begin
				div_dvd = mag(l_q);
				div_dvs = ad_q;
			end
			UOP_SAVE_TA: begin
				div_dvd = mag(l_q);
				div_dvs = bd_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	rau_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// multiplier operand selection
	always_comb begin
		ma = '0;
		mb = '0;
		case (uop)
			UOP_MUL_1: begin
				ma = {an_q[W-1], an_q};
				mb = (op_q == OP_MUL) ? {bn_q[W-1], bn_q} : {bd_q[W-1], bd_q};
			end
			UOP_MUL_2: begin
				ma = {ad_q[W-1], ad_q};
				mb = (op_q == OP_MUL) ? {bd_q[W-1], bd_q} : {bn_q[W-1], bn_q};
			end
			UOP_MUL_L: begin
				ma = {1'b0, div_quo};
				mb = {mi_q[W-1], mi_q};
			end
			UOP_MUL_TA: begin
				ma = {an_q[W-1], an_q};
				mb = {1'b0, div_quo};
			end
			UOP_MUL_TB: begin
				ma = {bn_q[W-1], bn_q};
				mb = {1'b0, div_quo};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// registers updated by micro-operation
	always_ff @(posedge clk) begin
		case (uop)
			UOP_LOAD: begin
				op_q  <= opcode;
				nn_q  <= a_num[W-1:0];
				nd_q  <= a_den[W-1:0];
				bn0_q <= b_num[W-1:0];
				bd0_q <= bd_ext[W-1:0];
			end
			UOP_RES_ZERO: begin
				rn_q     <= '0;
				rd_q     <= RD_ONE;
				truth_q  <= 1'b0;
				status_q <= 1'b0;
			end
			UOP_N_CHK: begin
				nok_q <= nd_q != '0;
				ga_q  <= mag(nn_q);
				gb_q  <= mag(nd_q);
			end
			UOP_G_SHIFT: begin
				ga_q <= gb_q;
				gb_q <= div_rem;
			end
			UOP_G_END:   g_q  <= ga_q;
			UOP_SAVE_QN: qn_q <= div_quo;
			UOP_N_END: begin
				if (div_quo[W-1])
					nok_q <= 1'b0;
				on_q <= neg ? (~qn_q + 1'b1) : qn_q;
				od_q <= div_quo;
			end
			UOP_FAIL: begin
				rn_q     <= '0;
				rd_q     <= RD_ONE;
				truth_q  <= 1'b0;
				status_q <= 1'b1;
			end
			UOP_SET_A: begin
				an_q <= on_q;
				ad_q <= od_q;
				nn_q <= bn0_q;
				nd_q <= bd0_q;
			end
			UOP_SET_B: begin
				bn_q <= on_q;
				bd_q <= od_q;
			end
			UOP_RES_A: begin
				rn_q     <= an_q;
				rd_q     <= ad_q[W-2:0];
				truth_q  <= 1'b0;
				status_q <= 1'b0;
			end
			UOP_MUL_1: prod_q <= ma * mb;
			UOP_MUL_2: begin
				t1_q   <= pw;
				x_q    <= prod_q;
				prod_q <= ma * mb;
			end
			UOP_LD_PROD: begin
				nn_q <= t1_q;
				nd_q <= pw;
			end
			UOP_CMP: begin
				rn_q     <= '0;
				rd_q     <= RD_ONE;
				truth_q  <= cmp_r;
				status_q <= 1'b0;
			end
			UOP_FLOOR: begin
				rn_q     <= fl;
				rd_q     <= RD_ONE;
				truth_q  <= 1'b0;
				status_q <= 1'b0;
				bn_q     <= fl;
				bd_q     <= W_ONE;
			end
			UOP_AS_EQ: begin
				nn_q <= sub ? (an_q - bn_q) : (an_q + bn_q);
				nd_q <= ad_q;
			end
			UOP_AS_GCD: begin
				mx_q <= (ad_q > bd_q) ? ad_q : bd_q;
				mi_q <= (ad_q > bd_q) ? bd_q : ad_q;
				ga_q <= (ad_q > bd_q) ? ad_q : bd_q;
				gb_q <= (ad_q > bd_q) ? bd_q : ad_q;
			end
			UOP_MUL_L:   prod_q <= ma * mb;
			UOP_SAVE_L:  l_q    <= pw;
			UOP_MUL_TA:  prod_q <= ma * mb;
			UOP_SAVE_TA: ta_q   <= l_q[W-1] ? neg_pw : pw;
			UOP_MUL_TB:  prod_q <= ma * mb;
			UOP_SUM: begin
				nn_q <= sum;
				nd_q <= l_q;
			end
			UOP_FIN: begin
				rn_q     <= nok_q ? on_q : '0;
				rd_q     <= nok_q ? od_q[W-2:0] : RD_ONE;
				truth_q  <= 1'b0;
				status_q <= ~nok_q;
			end
			default: begin
			end
		endcase
	end

	// status to controller
	assign sts.op       = op_q;
	assign sts.nd_zero  = nd_q == '0;
	assign sts.gb_zero  = gb_q == '0;
	assign sts.nok      = nok_q;
	assign sts.div_done = div_done;
	assign sts.ad_eq_bd = ad_q == bd_q;

	// result fields
	assign res_num = NUM_BITS'(rn_q);
	assign res_den = DEN_BITS'(rd_q);
	assign truth   = truth_q;
	assign status  = status_q;

endmodule

`default_nettype wire

[hw/rtl/rau_ctrl.sv]
// controller: sequences normalize, gcd and operation steps
`default_nettype none

module rau_ctrl import rau_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     out_ready,
	input  wire rau_sts_t sts,
	output logic          in_ready,
	output logic          out_valid,
	output rau_uop_t      uop
);

	localparam int NS = 27;

	typedef enum logic [NS-1:0] {
		ST_IDLE   = NS'(1) << 0,
		ST_DISP   = NS'(1) << 1,
		ST_N_CHK  = NS'(1) << 2,
		ST_G_TEST = NS'(1) << 3,
		ST_G_WAIT = NS'(1) << 4,
		ST_N_QN   = NS'(1) << 5,
		ST_N_QNW  = NS'(1) << 6,
		ST_N_QD   = NS'(1) << 7,
		ST_N_QDW  = NS'(1) << 8,
		ST_A_DONE = NS'(1) << 9,
		ST_B_DONE = NS'(1) << 10,
		ST_OPS    = NS'(1) << 11,
		ST_M_2    = NS'(1) << 12,
		ST_M_3    = NS'(1) << 13,
		ST_C_3    = NS'(1) << 14,
		ST_F_W    = NS'(1) << 15,
		ST_AS_EQ  = NS'(1) << 16,
		ST_AS_L1  = NS'(1) << 17,
		ST_AS_L1W = NS'(1) << 18,
		ST_AS_L2  = NS'(1) << 19,
		ST_AS_TA  = NS'(1) << 20,
		ST_AS_TAW = NS'(1) << 21,
		ST_AS_TA2 = NS'(1) << 22,
		ST_AS_TBW = NS'(1) << 23,
		ST_AS_SUM = NS'(1) << 24,
		ST_FIN    = NS'(1) << 25,
		ST_OUT    = NS'(1) << 26
	} rau_state_t;

	rau_state_t state_q, state_d, ret_q, ret_d, gret_q, gret_d;
	logic       uses_b, is_cmp;

	assign uses_b = sts.op inside {[OP_ADD:OP_GE]};
	assign is_cmp = sts.op inside {[OP_EQ:OP_GE]};

	// next state and micro-operation
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		gret_d  = gret_q;
		uop     = UOP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					uop     = UOP_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				uop = UOP_RES_ZERO;
				if (sts.op > OP_FRAC) begin
					state_d = ST_OUT;
				end else begin
					ret_d   = ST_A_DONE;
					state_d = ST_N_CHK;
				end
			end
			// normalize: zero check then gcd
			ST_N_CHK: begin
				uop = UOP_N_CHK;
				if (sts.nd_zero) begin
					state_d = ret_q;
				end else begin
					gret_d  = ST_N_QN;
					state_d = ST_G_TEST;
				end
			end
			// euclid loop
			ST_G_TEST: begin
				if (sts.gb_zero) begin
					uop     = UOP_G_END;
					state_d = gret_q;
				end else begin
					uop     = UOP_G_STEP;
					state_d = ST_G_WAIT;
				end
			end
			ST_G_WAIT: begin
				if (sts.div_done) begin
					uop     = UOP_G_SHIFT;
					state_d = ST_G_TEST;
				end
			end
			// divide both parts by the gcd
			ST_N_QN: begin
				uop     = UOP_DIV_QN;
				state_d = ST_N_QNW;
			end
			ST_N_QNW: begin
				if (sts.div_done) begin
					uop     = UOP_SAVE_QN;
					state_d = ST_N_QD;
				end
			end
			ST_N_QD: begin
				uop     = UOP_DIV_QD;
				state_d = ST_N_QDW;
			end
			ST_N_QDW: begin
				if (sts.div_done) begin
					uop     = UOP_N_END;
					state_d = ret_q;
				end
			end
			ST_A_DONE: begin
				if (!sts.nok) begin
					uop     = UOP_FAIL;
					state_d = ST_OUT;
				end else begin
					uop = UOP_SET_A;
					if (uses_b) begin
						ret_d   = ST_B_DONE;
						state_d = ST_N_CHK;
					end else begin
						state_d = ST_OPS;
					end
				end
			end
			ST_B_DONE: begin
				if (!sts.nok) begin
					uop     = UOP_FAIL;
					state_d = ST_OUT;
				end else begin
					uop     = UOP_SET_B;
					state_d = ST_OPS;
				end
			end
			// operation dispatch
			ST_OPS: begin
				case (sts.op)
					OP_NORM: begin
						uop     = UOP_RES_A;
						state_d = ST_OUT;
					end
					OP_ADD, OP_SUB: state_d = ST_AS_EQ;
					OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
						uop     = UOP_MUL_1;
						state_d = ST_M_2;
					end
					OP_FLOOR, OP_FRAC: begin
						uop     = UOP_DIV_FL;
						state_d = ST_F_W;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_M_2: begin
				uop     = UOP_MUL_2;
				state_d = is_cmp ? ST_C_3 : ST_M_3;
			end
			ST_M_3: begin
				uop     = UOP_LD_PROD;
				ret_d   = ST_FIN;
				state_d = ST_N_CHK;
			end
			ST_C_3: begin
				uop     = UOP_CMP;
				state_d = ST_OUT;
			end
			ST_F_W: begin
				if (sts.div_done) begin
					uop     = UOP_FLOOR;
					state_d = (sts.op == OP_FLOOR) ? ST_OUT : ST_AS_EQ;
				end
			end
			// add and subtract over the lcm
			ST_AS_EQ: begin
				if (sts.ad_eq_bd) begin
					uop     = UOP_AS_EQ;
					ret_d   = ST_FIN;
					state_d = ST_N_CHK;
				end else begin
					uop     = UOP_AS_GCD;
					gret_d  = ST_AS_L1;
					state_d = ST_G_TEST;
				end
			end
			ST_AS_L1: begin
				uop     = UOP_DIV_L;
				state_d = ST_AS_L1W;
			end
			ST_AS_L1W: begin
				if (sts.div_done) begin
					uop     = UOP_MUL_L;
					state_d = ST_AS_L2;
				end
			end
			ST_AS_L2: begin
				uop     = UOP_SAVE_L;
				state_d = ST_AS_TA;
			end
			ST_AS_TA: begin
				uop     = UOP_DIV_TA;
				state_d = ST_AS_TAW;
			end
			ST_AS_TAW: begin
				if (sts.div_done) begin
					uop     = UOP_MUL_TA;
					state_d = ST_AS_TA2;
				end
			end
			ST_AS_TA2: begin
				uop     = UOP_SAVE_TA;
				state_d = ST_AS_TBW;
			end
			ST_AS_TBW: begin
				if (sts.div_done) begin
					uop     = UOP_MUL_TB;
					state_d = ST_AS_SUM;
				end
			end
			ST_AS_SUM: begin
				uop     = UOP_SUM;
				ret_d   = ST_FIN;
				state_d = ST_N_CHK;
			end
			ST_FIN: begin
				uop     = UOP_FIN;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			gret_q  <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			gret_q  <= gret_d;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;

endmodule

`default_nettype wire

[hw/rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: one request in flight, result held until taken.
// All divisions run one at a time on the shared bit-serial divider, and a
// normalize costs (gcd steps + 2) divider uses, so latency grows with the number of
// divider uses; an undefined opcode skips normalize and goes straight to the result.
// A new request is accepted in the cycle after the previous result is taken.
// Reset clears the controller and divider control asynchronously; no clearing pass.
`default_nettype none

module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	rau_in_if.sink   operands,
	rau_out_if.source result
);

	rau_uop_t uop;
	rau_sts_t sts;
	logic     in_ready;

	// controller
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (result.valid),
		.uop       (uop)
	);

	assign operands.ready = in_ready;

	// datapath
	rau_dp #(.W(WORD_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.uop     (uop),
		.opcode  (operands.opcode),
		.a_num   (operands.a_num),
		.a_den   (operands.a_den),
		.b_num   (operands.b_num),
		.b_den   (operands.b_den),
		.sts     (sts),
		.res_num (result.res_num),
		.res_den (result.res_den),
		.truth   (result.truth),
		.status  (result.status)
	);

endmodule

`default_nettype wire

[hw/rtl/rau_checker.sv]
// port-level checks for the rational arithmetic unit and their binding
`default_nettype none

module rau_checker import rau_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [NUM_BITS-1:0] res_num,
	input wire logic [DEN_BITS-1:0]        res_den,
	input wire logic                       truth,
	input wire logic                       status
);

	// one request at a time: never ready while a result waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request accepted while result pending");

	// an accepted request blocks the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after accept");

	// error results carry zero over one
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (res_num == '0 && res_den == DEN_BITS'(1) && !truth))
		else $error("error result not zero over one");

	// denominator is always positive
	a_den_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_den != '0))
		else $error("zero result denominator");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_num) && $stable(res_den)
			&& $stable(truth) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (operands.valid),
	.in_ready  (operands.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.res_num   (result.res_num),
	.res_den   (result.res_den),
	.truth     (result.truth),
	.status    (result.status)
);

`default_nettype wire
